### hdl/sorted_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue
// Implication and next-cycle checks on the rising clock edge, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication
`define SPQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Sizes, types and codes shared by the cells and the top level of the queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int CAPACITY    = 64;
  localparam int TAG_WIDTH   = 16;
  localparam int PRIO_W      = 16;
  localparam int PAYLOAD_W   = 16;
  localparam int COUNT_OUT_W = 7;
  // occupancy must be able to hold CAPACITY itself
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [TAG_WIDTH-1:0]     tag_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REMOVED  = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic  do_insert;
    logic  do_remove;
    prio_t new_prio;
    tag_t  new_tag;
  } cell_ctl_t;

endpackage

### hdl/sorted_priority_queue.sv
// Each beat's result is registered at the edge that accepts it.
// Throughput: one beat per cycle while results are taken; every cell compares
// and shifts in parallel, so each insert or remove completes at the edge that accepts it.
// The output register frees whenever its result is taken, so input stalls
// only while a result waits downstream.
// Reset clears the occupancy and the output valid; slot contents are kept.
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a chain of cells sorted from the head,
// highest priority first; ties leave in arrival order.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic signed [15:0]     priority_req,
  input  logic [PAYLOAD_W-1:0]   payload,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             status,
  output logic signed [15:0]     out_priority,
  output logic [PAYLOAD_W-1:0]   out_payload,
  output logic [COUNT_OUT_W-1:0] count
);

`include "sorted_priority_queue_assert.svh"

  cnt_t      occupancy;
  cnt_t      occupancy_next;
  cell_ctl_t ctl;
  logic      in_fire;
  logic      is_full;
  logic      is_empty;
  status_t   stat_next;

  logic  cell_keep [CAPACITY];
  logic  cell_occ  [CAPACITY];
  prio_t cell_prio [CAPACITY];
  tag_t  cell_tag  [CAPACITY];

  // handshake: take a beat whenever the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign is_full  = (occupancy == cnt_t'(CAPACITY));
  assign is_empty = (occupancy == '0);

  // broadcast operation
  always_comb begin
    ctl.do_insert = in_fire && (cmd == CMD_INSERT) && !is_full;
    ctl.do_remove = in_fire && (cmd == CMD_REMOVE) && !is_empty;
    ctl.new_prio  = priority_req;
    ctl.new_tag   = TAG_WIDTH'(payload);
  end

  // status and next occupancy
  always_comb begin
    occupancy_next = occupancy;
    if (cmd == CMD_INSERT) begin
      stat_next = is_full ? STAT_FULL : STAT_INSERTED;
      if (!is_full) occupancy_next = occupancy + cnt_t'(1);
    end else begin
      stat_next = is_empty ? STAT_EMPTY : STAT_REMOVED;
      if (!is_empty) occupancy_next = occupancy - cnt_t'(1);
    end
  end

  // chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    prio_t p_prio;
    tag_t  p_tag;
    logic  p_keep;
    prio_t n_prio;
    tag_t  n_tag;

    assign cell_occ[i] = (cnt_t'(i) < occupancy);

    if (i == 0) begin : g_head
      assign p_keep = 1'b1;
      assign p_prio = '0;
      assign p_tag  = '0;
    end else begin : g_body
      assign p_keep = cell_keep[i-1];
      assign p_prio = cell_prio[i-1];
      assign p_tag  = cell_tag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_prio = cell_prio[i];
      assign n_tag  = cell_tag[i];
    end else begin : g_inner
      assign n_prio = cell_prio[i+1];
      assign n_tag  = cell_tag[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (cell_occ[i]),
      .prev_keep (p_keep),
      .prev_prio (p_prio),
      .prev_tag  (p_tag),
      .next_prio (n_prio),
      .next_tag  (n_tag),
      .keep      (cell_keep[i]),
      .prio      (cell_prio[i]),
      .tag       (cell_tag[i])
    );
  end

  // occupancy and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) occupancy <= occupancy_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      status <= stat_next;
      count  <= COUNT_OUT_W'(occupancy_next);
      if (stat_next == STAT_REMOVED) begin
        out_priority <= cell_prio[0];
        out_payload  <= PAYLOAD_W'(cell_tag[0]);
      end else begin
        out_priority <= '0;
        out_payload  <= '0;
      end
    end
  end

  // checks
  `SPQ_ASSERT_IMPL(a_occ_bound, clk, rst, 1'b1, occupancy <= cnt_t'(CAPACITY), "occupancy overrun")
  `SPQ_ASSERT_NEXT(a_empty_rej, clk, rst, in_fire && cmd == CMD_REMOVE && is_empty, out_valid && status == STAT_EMPTY && occupancy == '0, "empty remove not rejected")
  `SPQ_ASSERT_NEXT(a_ins_grow, clk, rst, in_fire && cmd == CMD_INSERT && !is_full, occupancy == $past(occupancy) + cnt_t'(1), "insert did not grow queue")
  `SPQ_ASSERT_IMPL(a_zero_fields, clk, rst, out_valid && status != STAT_REMOVED, out_priority == '0 && out_payload == '0, "non-removal result carries data")

endmodule

### hdl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the incoming
// priority, and holds, loads the new entry or takes a neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,   // slot lies below the occupancy
  input  logic      prev_keep,  // slot towards the head keeps its entry
  input  prio_t     prev_prio,
  input  tag_t      prev_tag,
  input  prio_t     next_prio,
  input  tag_t      next_tag,
  output logic      keep,
  output prio_t     prio,
  output tag_t      tag
);

  // stored entry stays put on insert when its priority is equal or greater
  assign keep = occupied && (prio >= ctl.new_prio);

  // slot update: hold, load new, shift towards tail, or shift towards head
  always_ff @(posedge clk) begin
    if (ctl.do_insert) begin
      if (!keep) begin
        if (prev_keep) begin
          prio <= ctl.new_prio;
          tag  <= ctl.new_tag;
        end else begin
          prio <= prev_prio;
          tag  <= prev_tag;
        end
      end
    end else if (ctl.do_remove) begin
      prio <= next_prio;
      tag  <= next_tag;
    end
  end

endmodule
